// ===== rtl/bor_pkg.sv =====
// Package for the box overlap ratios unit.
// Register indexes and threshold width; no dependencies.
package bor_pkg;
  localparam int THR_W = 16;
  localparam int CFG_IDX_W = 1;
  localparam logic [CFG_IDX_W-1:0] CFG_MATCH_THR = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_IOU_THR   = 1'b1;
endpackage

// ===== rtl/bor_div.sv =====
// Pipelined fractional divider, one quotient bit per stage.
// Requires num <= den; gives floor(num * 2^(QB-1) / den). No dependencies.
module bor_div #(
  parameter int W  = 25,
  parameter int QB = 16
) (
  input  logic          clk,
  input  logic [W-1:0]  num,
  input  logic [W-1:0]  den,
  output logic [QB-1:0] quot
);
  logic [W-1:0]  rem_r [QB];
  logic [W-1:0]  den_r [QB];
  logic [QB-1:0] q_r   [QB];

  for (genvar i = 0; i < QB; i++) begin : g_stage
    logic [W:0]    shifted;
    logic [W-1:0]  d_src;
    logic [QB-1:0] q_src;
    logic          ge;
    logic [W:0]    diff;
    if (i == 0) begin : g_first
      assign shifted = {1'b0, num};
      assign d_src   = den;
      assign q_src   = '0;
    end else begin : g_next
      assign shifted = {rem_r[i-1], 1'b0};
      assign d_src   = den_r[i-1];
      assign q_src   = q_r[i-1];
    end
    assign ge   = shifted >= {1'b0, d_src};
    assign diff = shifted - {1'b0, d_src};
    always_ff @(posedge clk) begin
      rem_r[i] <= ge ? diff[W-1:0] : shifted[W-1:0];
      den_r[i] <= d_src;
      q_r[i]   <= {q_src[QB-2:0], ge};
    end
  end

  assign quot = q_r[QB-1];
endmodule

// ===== rtl/box_overlap_ratios_unit.sv =====
// Top level of the box overlap ratios unit: IoU and containment of two boxes.
// Depends on bor_pkg and bor_div.
//
// Usage: drive the eight box fields and pulse start; busy stays low, so a
// transfer is taken every cycle start is high. Each item yields one result,
// shown for one cycle with out_valid high. Throughput is one item per cycle.
// The pipeline has three arithmetic stages (overlap, products, union and
// minimum), one divider stage per quotient bit, and the output register:
// RATIO_FRAC_BITS + 5 registers, the first loaded at the transfer edge.
// Both ratios are divided in parallel by two pipelined dividers.
// Thresholds are written through cfg_we/cfg_index/cfg_data while idle.
// Reset (synchronous, rst_n low) clears all valid bits, dropping items in
// flight, and loads the default thresholds. The receiver cannot stall:
// results are not held.
module box_overlap_ratios_unit #(
  parameter int COORD_BITS      = 12,
  parameter int RATIO_FRAC_BITS = 15
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         start,
  output logic                         busy,
  input  logic [COORD_BITS-1:0]        in_a_x,
  input  logic [COORD_BITS-1:0]        in_a_y,
  input  logic [COORD_BITS-1:0]        in_a_width,
  input  logic [COORD_BITS-1:0]        in_a_height,
  input  logic [COORD_BITS-1:0]        in_b_x,
  input  logic [COORD_BITS-1:0]        in_b_y,
  input  logic [COORD_BITS-1:0]        in_b_width,
  input  logic [COORD_BITS-1:0]        in_b_height,
  input  logic                         cfg_we,
  input  logic [bor_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [bor_pkg::THR_W-1:0]    cfg_data,
  output logic                         out_valid,
  output logic [RATIO_FRAC_BITS:0]     out_iou_ratio,
  output logic [RATIO_FRAC_BITS:0]     out_containment_ratio,
  output logic                         out_boxes_matched,
  output logic                         out_iou_above,
  output logic                         out_degenerate
);
  localparam int C  = COORD_BITS;
  localparam int AW = 2 * C;
  localparam int UW = AW + 1;
  localparam int QB = RATIO_FRAC_BITS + 1;
  localparam int CW = (QB > bor_pkg::THR_W) ? QB : bor_pkg::THR_W;
  localparam logic [bor_pkg::THR_W-1:0] MATCH_RST = 16'd19661;
  localparam logic [bor_pkg::THR_W-1:0] IOU_RST   = 16'd16384;

  logic [bor_pkg::THR_W-1:0] match_thr_r, iou_thr_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      match_thr_r <= MATCH_RST;
      iou_thr_r   <= IOU_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        bor_pkg::CFG_MATCH_THR: match_thr_r <= cfg_data;
        bor_pkg::CFG_IOU_THR:   iou_thr_r   <= cfg_data;
        default: ;
      endcase
    end
  end

  assign busy = 1'b0;
  logic in_xfer;
  assign in_xfer = start & ~busy;

  // stage 1: overlap lengths
  function automatic logic [C-1:0] ovl(input logic [C-1:0] s0, input logic [C-1:0] l0,
                                       input logic [C-1:0] s1, input logic [C-1:0] l1);
    logic [C:0] e0, e1, hi, lo;
    e0 = {1'b0, s0} + {1'b0, l0};
    e1 = {1'b0, s1} + {1'b0, l1};
    lo = (s0 > s1) ? {1'b0, s0} : {1'b0, s1};
    hi = (e0 < e1) ? e0 : e1;
    ovl = (hi > lo) ? C'(hi - lo) : '0;
  endfunction

  logic         s1_v_r;
  logic [C-1:0] wx_r, wy_r, aw_r, ah_r, bw_r, bh_r;

  always_ff @(posedge clk) begin
    if (!rst_n) s1_v_r <= 1'b0;
    else        s1_v_r <= in_xfer;
    wx_r <= ovl(in_a_x, in_a_width, in_b_x, in_b_width);
    wy_r <= ovl(in_a_y, in_a_height, in_b_y, in_b_height);
    aw_r <= in_a_width;
    ah_r <= in_a_height;
    bw_r <= in_b_width;
    bh_r <= in_b_height;
  end

  // stage 2: products
  logic          s2_v_r;
  logic [AW-1:0] inter_r, area_a_r, area_b_r;

  always_ff @(posedge clk) begin
    if (!rst_n) s2_v_r <= 1'b0;
    else        s2_v_r <= s1_v_r;
    inter_r  <= {{C{1'b0}}, wx_r} * {{C{1'b0}}, wy_r};
    area_a_r <= {{C{1'b0}}, aw_r} * {{C{1'b0}}, ah_r};
    area_b_r <= {{C{1'b0}}, bw_r} * {{C{1'b0}}, bh_r};
  end

  // stage 3: union, smaller area, flags
  logic          s3_v_r, s3_dg_r, s3_uz_r;
  logic [UW-1:0] num_r, uni_r, amin_r;

  always_ff @(posedge clk) begin
    if (!rst_n) s3_v_r <= 1'b0;
    else        s3_v_r <= s2_v_r;
    num_r   <= {1'b0, inter_r};
    uni_r   <= {1'b0, area_a_r} + {1'b0, area_b_r} - {1'b0, inter_r};
    amin_r  <= {1'b0, (area_a_r < area_b_r) ? area_a_r : area_b_r};
    s3_dg_r <= (area_a_r == '0) || (area_b_r == '0);
    s3_uz_r <= (area_a_r == '0) && (area_b_r == '0);
  end

  logic [QB-1:0] q_iou, q_cont;

  bor_div #(.W(UW), .QB(QB)) u_div_iou (
    .clk(clk), .num(num_r), .den(uni_r), .quot(q_iou)
  );
  bor_div #(.W(UW), .QB(QB)) u_div_cont (
    .clk(clk), .num(num_r), .den(amin_r), .quot(q_cont)
  );

  logic [QB-1:0] v_pipe_r, dg_pipe_r, uz_pipe_r;

  always_ff @(posedge clk) begin
    if (!rst_n) v_pipe_r <= '0;
    else        v_pipe_r <= {v_pipe_r[QB-2:0], s3_v_r};
    dg_pipe_r <= {dg_pipe_r[QB-2:0], s3_dg_r};
    uz_pipe_r <= {uz_pipe_r[QB-2:0], s3_uz_r};
  end

  // output register
  logic [QB-1:0] iou_nxt, cont_nxt;
  assign iou_nxt  = uz_pipe_r[QB-1] ? '0 : q_iou;
  assign cont_nxt = dg_pipe_r[QB-1] ? '0 : q_cont;

  always_ff @(posedge clk) begin
    if (!rst_n) out_valid <= 1'b0;
    else        out_valid <= v_pipe_r[QB-1];
    out_iou_ratio         <= iou_nxt;
    out_containment_ratio <= cont_nxt;
    out_boxes_matched     <= CW'(cont_nxt) > CW'(match_thr_r);
    out_iou_above         <= CW'(iou_nxt) > CW'(iou_thr_r);
    out_degenerate        <= dg_pipe_r[QB-1];
  end
endmodule

// ===== bench/tb.sv =====
// Self-checking bench for box_overlap_ratios_unit: IoU, containment and flags.
// Depends on bor_pkg and the RTL; predicts each result and compares it in order.
`timescale 1ns / 100ps

module tb;
  localparam int CW = 12;
  localparam int FB = 15;
  localparam int LATENCY = FB + 5;

  typedef struct packed {
    logic [CW-1:0] ax, ay, aw, ah, bx, by, bw, bh;
  } box_pair_t;

  typedef struct packed {
    logic [FB:0] iou;
    logic [FB:0] cont;
    logic        matched;
    logic        iou_above;
    logic        degen;
  } overlap_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic start = 1'b0;
  logic busy;
  logic busy_s = 1'b1;
  logic [CW-1:0] in_a_x = '0, in_a_y = '0, in_a_width = '0, in_a_height = '0;
  logic [CW-1:0] in_b_x = '0, in_b_y = '0, in_b_width = '0, in_b_height = '0;
  logic cfg_we = 1'b0;
  logic [bor_pkg::CFG_IDX_W-1:0] cfg_index = bor_pkg::CFG_MATCH_THR;
  logic [bor_pkg::THR_W-1:0] cfg_data = '0;
  logic out_valid;
  logic [FB:0] out_iou_ratio, out_containment_ratio;
  logic out_boxes_matched, out_iou_above, out_degenerate;

  logic [bor_pkg::THR_W-1:0] match_thr = 16'd19661;
  logic [bor_pkg::THR_W-1:0] iou_thr = 16'd16384;
  overlap_t pending_ratios[$];
  int fails = 0;

  box_overlap_ratios_unit u_dut (
    .clk, .rst_n, .start, .busy,
    .in_a_x, .in_a_y, .in_a_width, .in_a_height,
    .in_b_x, .in_b_y, .in_b_width, .in_b_height,
    .cfg_we, .cfg_index, .cfg_data,
    .out_valid, .out_iou_ratio, .out_containment_ratio,
    .out_boxes_matched, .out_iou_above, .out_degenerate
  );

  always #10 clk = ~clk;
  always @(negedge clk) busy_s <= busy;

  function automatic longint unsigned span_overlap(longint unsigned s0, longint unsigned l0,
                                                   longint unsigned s1, longint unsigned l1);
    longint unsigned lo, hi;
    lo = (s0 > s1) ? s0 : s1;
    hi = (s0 + l0 < s1 + l1) ? s0 + l0 : s1 + l1;
    return (hi > lo) ? hi - lo : 0;
  endfunction

  function automatic longint unsigned q_div(longint unsigned num, longint unsigned den);
    return (den == 0) ? 0 : (num << FB) / den;
  endfunction

  function automatic overlap_t predict_overlap(box_pair_t p);
    longint unsigned inter, area_a, area_b, iou, ca, cb, cont;
    overlap_t r;
    inter = span_overlap(p.ax, p.aw, p.bx, p.bw) * span_overlap(p.ay, p.ah, p.by, p.bh);
    area_a = longint'(p.aw) * p.ah;
    area_b = longint'(p.bw) * p.bh;
    iou = q_div(inter, area_a + area_b - inter);
    ca = q_div(inter, area_a);
    cb = q_div(inter, area_b);
    cont = (ca > cb) ? ca : cb;
    r.iou = iou[FB:0];
    r.cont = cont[FB:0];
    r.matched = (r.cont > match_thr);
    r.iou_above = (r.iou > iou_thr);
    r.degen = (area_a == 0) || (area_b == 0);
    return r;
  endfunction

  always @(posedge clk) begin
    overlap_t exp_r, got;
    if (rst_n && out_valid) begin
      got = '{out_iou_ratio, out_containment_ratio, out_boxes_matched,
              out_iou_above, out_degenerate};
      if (pending_ratios.size() == 0) begin
        $display("%0t: unexpected result iou=%0d cont=%0d", $time, got.iou, got.cont);
        fails++;
      end else begin
        exp_r = pending_ratios.pop_front();
        if (got.iou !== exp_r.iou) begin
          $display("%0t: iou_ratio exp %0d got %0d", $time, exp_r.iou, got.iou);
          fails++;
        end
        if (got.cont !== exp_r.cont) begin
          $display("%0t: containment_ratio exp %0d got %0d", $time, exp_r.cont, got.cont);
          fails++;
        end
        if (got.matched !== exp_r.matched) begin
          $display("%0t: boxes_matched exp %0b got %0b", $time, exp_r.matched, got.matched);
          fails++;
        end
        if (got.iou_above !== exp_r.iou_above) begin
          $display("%0t: iou_above exp %0b got %0b", $time, exp_r.iou_above, got.iou_above);
          fails++;
        end
        if (got.degen !== exp_r.degen) begin
          $display("%0t: degenerate exp %0b got %0b", $time, exp_r.degen, got.degen);
          fails++;
        end
      end
    end
  end

  // called at a rising edge; start stays high so back-to-back calls form a burst
  task automatic send_pair(box_pair_t p);
    start <= 1'b1;
    {in_a_x, in_a_y, in_a_width, in_a_height, in_b_x, in_b_y, in_b_width, in_b_height} <= p;
    @(posedge clk);
    while (busy_s) @(posedge clk);
    pending_ratios.push_back(predict_overlap(p));
  endtask

  task automatic pause(int n);
    if (n > 0) begin
      start <= 1'b0;
      repeat (n) @(posedge clk);
    end
  endtask

  task automatic drain();
    pause(1);
    while (pending_ratios.size() != 0) @(posedge clk);
    repeat (LATENCY + 5) @(posedge clk);
  endtask

  task automatic write_thr(logic [bor_pkg::CFG_IDX_W-1:0] idx,
                           logic [bor_pkg::THR_W-1:0] val);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    if (idx == bor_pkg::CFG_MATCH_THR) match_thr = val;
    else iou_thr = val;
  endtask

  function automatic box_pair_t mk(int ax, ay, aw, ah, bx, by, bw, bh);
    box_pair_t p;
    p = '{ax[CW-1:0], ay[CW-1:0], aw[CW-1:0], ah[CW-1:0],
          bx[CW-1:0], by[CW-1:0], bw[CW-1:0], bh[CW-1:0]};
    return p;
  endfunction

  function automatic box_pair_t rand_pair();
    box_pair_t p;
    int kind;
    p = {$urandom, $urandom, $urandom};
    kind = $urandom_range(0, 9);
    if (kind < 6) begin
      // nearby boxes of modest size, so overlaps are common
      p.aw = CW'($urandom_range(0, 300));
      p.ah = CW'($urandom_range(0, 300));
      p.bx = CW'(p.ax + $urandom_range(0, 400) - 200);
      p.by = CW'(p.ay + $urandom_range(0, 400) - 200);
      p.bw = CW'($urandom_range(0, 300));
      p.bh = CW'($urandom_range(0, 300));
      if (kind == 0) {p.bx, p.by, p.bw, p.bh} = {p.ax, p.ay, p.aw, p.ah};
    end else if (kind == 6) begin
      if ($urandom_range(0, 1)) p.aw = 0; else p.bh = 0;
    end
    return p;
  endfunction

  task automatic test_directed();
    send_pair(mk(10, 10, 100, 50, 10, 10, 100, 50));            // identical
    send_pair(mk(0, 0, 10, 10, 100, 100, 10, 10));              // apart
    send_pair(mk(0, 0, 10, 10, 10, 0, 10, 10));                 // touching x
    send_pair(mk(0, 0, 10, 10, 0, 10, 10, 10));                 // touching y
    send_pair(mk(0, 0, 100, 100, 20, 20, 10, 10));              // contained
    send_pair(mk(0, 0, 0, 10, 0, 0, 10, 10));                   // zero area a
    send_pair(mk(0, 0, 10, 10, 5, 5, 10, 0));                   // zero area b
    send_pair(mk(0, 0, 0, 0, 0, 0, 0, 0));                      // both zero
    send_pair(mk(500, 500, 0, 9, 0, 0, 4, 4));                  // zero area, apart
    send_pair(mk(4095, 4095, 4095, 4095, 4095, 4095, 4095, 4095));
    send_pair(mk(0, 0, 4095, 4095, 4095, 4095, 4095, 4095));    // edges past range
    send_pair(mk(0, 0, 4095, 4095, 0, 0, 1, 1));
    send_pair(mk(0, 0, 1, 1, 0, 0, 4095, 4095));
    send_pair(mk(0, 0, 10, 10, 5, 0, 10, 10));
    send_pair(mk(0, 0, 3, 3, 1, 1, 3, 3));
    pause(3);
    send_pair(mk(100, 200, 64, 64, 132, 232, 64, 64));
    drain();
  endtask

  task automatic test_thresholds();
    logic [bor_pkg::THR_W-1:0] vals[5] = '{16'd0, 16'd32768, 16'hFFFF, 16'd32767, 16'd1};
    foreach (vals[i]) begin
      write_thr(bor_pkg::CFG_MATCH_THR, vals[i]);
      write_thr(bor_pkg::CFG_IOU_THR, vals[4 - i]);
      send_pair(mk(0, 0, 10, 10, 0, 0, 10, 10));
      send_pair(mk(0, 0, 10, 10, 5, 0, 10, 10));
      send_pair(mk(0, 0, 10, 10, 50, 0, 10, 10));
      send_pair(mk(0, 0, 65, 63, 1, 0, 64, 63));
      repeat (6) send_pair(rand_pair());
      drain();
    end
    write_thr(bor_pkg::CFG_MATCH_THR, 16'd19661);
    write_thr(bor_pkg::CFG_IOU_THR, 16'd16384);
  endtask

  task automatic test_random(int n);
    int sent = 0;
    int burst;
    while (sent < n) begin
      burst = $urandom_range(1, 24);
      repeat (burst) begin
        send_pair(rand_pair());
        sent++;
      end
      if ($urandom_range(0, 3) != 0) pause($urandom_range(1, 8));
      if (sent % 250 < burst) begin
        drain();
        write_thr(bor_pkg::CFG_MATCH_THR, bor_pkg::THR_W'($urandom_range(0, 32768)));
        write_thr(bor_pkg::CFG_IOU_THR, bor_pkg::THR_W'($urandom_range(0, 32768)));
      end
    end
    drain();
  endtask

  initial begin
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed();
    test_thresholds();
    test_random(1000);
    if (fails == 0) $display("TEST PASSED");
    else $display("TEST FAILED");
    $finish;
  end

  initial begin
    #4ms;
    $display("TEST FAILED");
    $finish;
  end
endmodule
